// ===== design/assert_macros.svh =====
// Concurrent assertion macros shared by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion on the block clock clk_i and reset rst_ni.
`define ASSERT_BLK(label, prop, msg) \
  `ASSERT_CLK_RST(label, clk_i, rst_ni, prop, msg)

`endif

// ===== design/smm_pkg.sv =====
// Package with sizes, action codes and shared types of the matrix multiplier.
package smm_pkg;

  localparam int SIZE    = 8;
  localparam int CNT_W   = $clog2(SIZE);
  localparam int ADDR_W  = $clog2(SIZE * SIZE);
  localparam int IDX_W   = 3;
  localparam int ELEM_W  = 16;
  localparam int MUL_W   = 2 * ELEM_W;
  localparam int PROD_W  = 35;

  localparam logic [1:0] ACT_LOAD_A = 2'd0;
  localparam logic [1:0] ACT_LOAD_B = 2'd1;
  localparam logic [1:0] ACT_RUN    = 2'd2;

  typedef struct packed {
    logic             vld;
    logic             first;
    logic             lastk;
    logic             lastall;
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
  } smm_ctl_t;

endpackage

// ===== design/smm_mac.sv =====
// Multiply and accumulate unit: registered product, then running sum over k.
module smm_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  smm_pkg::smm_ctl_t                     ctl_i,
  input  logic signed [smm_pkg::ELEM_W-1:0]     a_i,
  input  logic signed [smm_pkg::ELEM_W-1:0]     b_i,
  output logic                                  done_o,
  output smm_pkg::smm_ctl_t                     ctl_o,
  output logic signed [smm_pkg::PROD_W-1:0]     sum_o
);
  import smm_pkg::*;

  smm_ctl_t                  ctl_q;
  logic signed [MUL_W-1:0]   prod_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic signed [PROD_W-1:0]  sum_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= MUL_W'(a_i) * MUL_W'(b_i);
      if (ctl_q.vld) begin
        acc_q <= sum_d;
      end
    end
  end

  // A new output element restarts the sum from its first product.
  assign sum_d  = (ctl_q.first ? PROD_W'(0) : acc_q) + PROD_W'(prod_q);
  assign done_o = ctl_q.vld && ctl_q.lastk;
  assign ctl_o  = ctl_q;
  assign sum_o  = sum_d;

endmodule

// ===== design/square_matrix_multiply.sv =====
// Top level of the square matrix multiplier: element stores, sequencer and output register.
// Load items are accepted back to back while the block is idle.
// A run item yields SIZE*SIZE result items from a single MAC unit; the whole pipeline
// advances only while the output register is empty or being taken, so a receiver stall
// on a waiting result holds every item behind it.
// Reset (rst_ni low, asynchronous) clears the sequencer and output valid, not the stores.
module square_matrix_multiply (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          action_i,
  input  logic [smm_pkg::IDX_W-1:0]           row_i,
  input  logic [smm_pkg::IDX_W-1:0]           col_i,
  input  logic signed [smm_pkg::ELEM_W-1:0]   value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [smm_pkg::IDX_W-1:0]           out_row_o,
  output logic [smm_pkg::IDX_W-1:0]           out_col_o,
  output logic signed [smm_pkg::PROD_W-1:0]   product_value_o,
  output logic                                last_o
);
  import smm_pkg::*;

`include "assert_macros.svh"

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(SIZE - 1);

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  // The whole compute pipeline advances together whenever the output register can take a value.
  logic adv;
  logic in_acc;
  logic in_range;
  logic [ADDR_W-1:0] wr_addr, a_addr, b_addr;

  // Element stores, one synchronous memory per matrix.
  logic signed [ELEM_W-1:0] mem_a [SIZE*SIZE];
  logic signed [ELEM_W-1:0] mem_b [SIZE*SIZE];
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;

  smm_ctl_t ctl1_q, ctl1_d, ctl2;
  logic signed [PROD_W-1:0] sum;
  logic done;

  logic                     out_valid_q;
  logic [CNT_W-1:0]         out_row_q, out_col_q;
  logic signed [PROD_W-1:0] out_val_q;
  logic                     out_last_q;

  logic issue_end;
  logic out_take;
  logic last_take;
  logic last_pos;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign adv        = !out_valid_q || !out_stall_i;
  assign out_take   = out_valid_q && !out_stall_i;

  // Loads outside the matrix are dropped.
  assign in_range = (32'(row_i) < SIZE) && (32'(col_i) < SIZE);
  assign wr_addr  = ADDR_W'(ADDR_W'(row_i) * ADDR_W'(SIZE) + ADDR_W'(col_i));
  assign a_addr   = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(SIZE) + ADDR_W'(k_q));
  assign b_addr   = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(SIZE) + ADDR_W'(j_q));

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range && (action_i == ACT_LOAD_A)) begin
      mem_a[wr_addr] <= value_i;
    end
    if (adv) begin
      a_rd_q <= mem_a[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && in_range && (action_i == ACT_LOAD_B)) begin
      mem_b[wr_addr] <= value_i;
    end
    if (adv) begin
      b_rd_q <= mem_b[b_addr];
    end
  end

  // The k counter runs innermost, then the column, then the row, so that results leave in
  // row-major order.
  assign issue_end = (i_q == LAST_IDX) && (j_q == LAST_IDX) && (k_q == LAST_IDX);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (action_i == ACT_RUN)) begin
          state_d = ST_ISSUE;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          if (issue_end) begin
            state_d = ST_DRAIN;
          end
          if (k_q == LAST_IDX) begin
            k_d = '0;
            if (j_q == LAST_IDX) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end else begin
            k_d = k_q + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // The final result leaving means the pipeline is empty.
        if (out_take && out_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control that travels alongside the memory read data.
  always_comb begin
    ctl1_d         = '0;
    ctl1_d.vld     = (state_q == ST_ISSUE);
    ctl1_d.first   = (k_q == '0);
    ctl1_d.lastk   = (k_q == LAST_IDX);
    ctl1_d.lastall = issue_end;
    ctl1_d.row     = i_q;
    ctl1_d.col     = j_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
      ctl1_q  <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (adv) begin
        ctl1_q <= ctl1_d;
      end
    end
  end

  smm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .ctl_i  (ctl1_q),
    .a_i    (a_rd_q),
    .b_i    (b_rd_q),
    .done_o (done),
    .ctl_o  (ctl2),
    .sum_o  (sum)
  );

  // Output register: holds a finished element until the consumer takes it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && done) begin
      out_row_q  <= ctl2.row;
      out_col_q  <= ctl2.col;
      out_val_q  <= sum;
      out_last_q <= ctl2.lastall;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_row_o       = IDX_W'(out_row_q);
  assign out_col_o       = IDX_W'(out_col_q);
  assign product_value_o = out_val_q;
  assign last_o          = out_valid_q && out_last_q;

  // Helper terms that keep the assertions short.
  assign last_take = out_valid_o && last_o && !out_stall_i;
  assign last_pos  = (out_row_q == LAST_IDX) && (out_col_q == LAST_IDX);

  `ASSERT_BLK(a_out_only_busy, out_valid_o |-> in_stall_o, "result item while idle")
  `ASSERT_BLK(a_last_to_idle, last_take |=> !in_stall_o, "block not idle after last item")
  `ASSERT_BLK(a_last_index, last_o |-> last_pos, "last marker on wrong element")

endmodule

// ===== bench/smm_checker.sv =====
// Checker that predicts every matrix product item and compares it with the block output.
module smm_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [1:0]                        action_i,
  input  logic [smm_pkg::IDX_W-1:0]         row_i,
  input  logic [smm_pkg::IDX_W-1:0]         col_i,
  input  logic signed [smm_pkg::ELEM_W-1:0] value_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [smm_pkg::IDX_W-1:0]         out_row_i,
  input  logic [smm_pkg::IDX_W-1:0]         out_col_i,
  input  logic signed [smm_pkg::PROD_W-1:0] product_value_i,
  input  logic                              last_i,
  output int                                errors_o,
  output int                                pending_o
);

  import smm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]         row;
    logic [IDX_W-1:0]         col;
    logic signed [PROD_W-1:0] value;
    logic                     last;
  } product_t;

  logic signed [ELEM_W-1:0] a_elems [SIZE*SIZE];
  logic signed [ELEM_W-1:0] b_elems [SIZE*SIZE];
  product_t                 expected_products [$];
  product_t                 oldest;
  int                       mismatches  = 0;
  int                       outstanding = 0;

  assign errors_o  = mismatches;
  assign pending_o = outstanding;

  // Forms C = A times B from the current stores and queues it in row-major order.
  function automatic void queue_products();
    longint   acc;
    product_t item;
    for (int i = 0; i < SIZE; i++) begin
      for (int j = 0; j < SIZE; j++) begin
        acc = 0;
        for (int k = 0; k < SIZE; k++) begin
          acc += longint'(a_elems[i*SIZE+k]) * longint'(b_elems[k*SIZE+j]);
        end
        item.row   = IDX_W'(i);
        item.col   = IDX_W'(j);
        item.value = acc[PROD_W-1:0];
        item.last  = (i == SIZE - 1) && (j == SIZE - 1);
        expected_products.push_back(item);
      end
    end
    outstanding += SIZE * SIZE;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_products.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected item, expected none, actual row %0d col %0d value %0d",
                   $time, out_row_i, out_col_i, product_value_i);
        end else begin
          oldest = expected_products.pop_front();
          outstanding--;
          if (out_row_i !== oldest.row) report("out_row", oldest.row, out_row_i);
          if (out_col_i !== oldest.col) report("out_col", oldest.col, out_col_i);
          if (product_value_i !== oldest.value) begin
            report("product_value", longint'(oldest.value), longint'(product_value_i));
          end
          if (last_i !== oldest.last) report("last", oldest.last, last_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        case (action_i)
          ACT_LOAD_A: begin
            if (int'(row_i) < SIZE && int'(col_i) < SIZE) a_elems[row_i*SIZE+col_i] = value_i;
          end
          ACT_LOAD_B: begin
            if (int'(row_i) < SIZE && int'(col_i) < SIZE) b_elems[row_i*SIZE+col_i] = value_i;
          end
          ACT_RUN: begin
            queue_products();
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ===== bench/tb.sv =====
// Testbench top for the square matrix multiplier: stimulus, receiver stalls and verdict.
module tb;

  import smm_pkg::*;

  // Action code that the block must ignore.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 64;
  localparam int CYCLE_LIMIT  = 2000000;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = -16'sd32768;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 16'sd32767;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic [1:0]                action_i;
  logic [IDX_W-1:0]          row_i;
  logic [IDX_W-1:0]          col_i;
  logic signed [ELEM_W-1:0]  value_i;
  logic                      out_valid_o;
  logic                      out_stall_i = 1'b0;
  logic [IDX_W-1:0]          out_row_o;
  logic [IDX_W-1:0]          out_col_o;
  logic signed [PROD_W-1:0]  product_value_o;
  logic                      last_o;

  int errors;
  int pending;
  int in_idle_pct  = 7;
  int out_idle_pct = 86;
  int cycle_count  = 0;

  // The clock runs with a period of 10 time units.
  always #5 clk_i = ~clk_i;

  square_matrix_multiply i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

  // The checker watches both channels beside the block and counts every failure.
  smm_checker i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .action_i        (action_i),
    .row_i           (row_i),
    .col_i           (col_i),
    .value_i         (value_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_i       (out_row_o),
    .out_col_i       (out_col_o),
    .product_value_i (product_value_o),
    .last_i          (last_o),
    .errors_o        (errors),
    .pending_o       (pending)
  );

  // The receiver stalls at random with the rate of the current phase. The stall is
  // a fresh draw at every edge, so gaps land on every step of the output stream.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < out_idle_pct);
  end

  // Watchdog: a hung block or a lost result item ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Element values lean on the two extremes now and then so that the sums often sit
  // near the ends of the product range.
  function automatic logic signed [ELEM_W-1:0] pick_value();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return ELEM_MIN;
    if (sel == 1) return ELEM_MAX;
    return ELEM_W'($urandom);
  endfunction

  // Offers one item and returns at the edge where it was taken. It is called at a
  // rising edge. Idle cycles only ever lower valid, and valid is raised in a step
  // of its own, so no signal gets two nonblocking assignments in one step. While
  // stalled, the payload holds.
  task automatic send_item(input logic [1:0] act, input logic [IDX_W-1:0] r,
                           input logic [IDX_W-1:0] c, input logic signed [ELEM_W-1:0] v);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    row_i      <= r;
    col_i      <= c;
    value_i    <= v;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Writes every element of one matrix, with one fixed value or random values.
  // A full fill guarantees that no later product reads an element never written.
  task automatic fill_matrix(input logic [1:0] act, input logic signed [ELEM_W-1:0] fixed,
                             input bit use_random);
    for (int r = 0; r < SIZE; r++) begin
      for (int c = 0; c < SIZE; c++) begin
        send_item(act, IDX_W'(r), IDX_W'(c), use_random ? pick_value() : fixed);
      end
    end
  endtask

  task automatic set_phase(input int sender_pct, input int receiver_pct);
    in_idle_pct  = sender_pct;
    out_idle_pct = receiver_pct;
  endtask

  initial begin
    int sel;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    action_i   <= ACT_LOAD_A;
    row_i      <= '0;
    col_i      <= '0;
    value_i    <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First phase: the sender rarely idles and the receiver mostly stalls.
    set_phase(7, 86);

    // Both matrices at the most negative element give the largest positive sum.
    fill_matrix(ACT_LOAD_A, ELEM_MIN, 1'b0);
    fill_matrix(ACT_LOAD_B, ELEM_MIN, 1'b0);
    send_item(ACT_RUN, '0, '0, '0);

    // Against the most positive element, the sums reach their most negative value.
    fill_matrix(ACT_LOAD_B, ELEM_MAX, 1'b0);
    send_item(ACT_RUN, '1, '1, '1);

    // Fully random contents, then single corner writes over them.
    fill_matrix(ACT_LOAD_A, '0, 1'b1);
    fill_matrix(ACT_LOAD_B, '0, 1'b1);
    send_item(ACT_RUN, '0, '0, '0);
    send_item(ACT_LOAD_A, '0, '0, '0);
    send_item(ACT_LOAD_A, '1, '1, -16'sd1);
    send_item(ACT_LOAD_A, '0, '1, ELEM_MIN);
    send_item(ACT_LOAD_B, '1, '0, ELEM_MAX);
    send_item(ACT_LOAD_B, '0, '1, ELEM_MIN);
    send_item(ACT_LOAD_B, '1, '1, 16'sh5555);
    send_item(ACT_LOAD_A, 3'd5, 3'd2, 16'shAAAA);

    // The unused action must change nothing, whatever its fields hold.
    send_item(ACT_UNUSED, '1, '1, -16'sd1);
    send_item(ACT_UNUSED, '0, '0, '0);
    send_item(ACT_RUN, '0, '0, '0);
    send_item(ACT_UNUSED, 3'd2, 3'd6, ELEM_MAX);
    send_item(ACT_RUN, '1, '0, ELEM_MIN);

    // Random part: mostly loads with random content and a run now and then, with
    // a few unused actions as noise. The idle rates switch twice along the way, and
    // every phase closes with a run so that each one sees result items.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) set_phase(86, 7);
      if (n == 2 * RANDOM_ITEMS / 3) set_phase(0, 0);
      sel = $urandom_range(99);
      if ((n == RANDOM_ITEMS / 3 - 1) || (n == 2 * RANDOM_ITEMS / 3 - 1) ||
          (n == RANDOM_ITEMS - 1)) begin
        sel = 90;
      end
      if (sel < 40) begin
        send_item(ACT_LOAD_A, IDX_W'($urandom), IDX_W'($urandom), pick_value());
      end else if (sel < 80) begin
        send_item(ACT_LOAD_B, IDX_W'($urandom), IDX_W'($urandom), pick_value());
      end else if (sel < 95) begin
        send_item(ACT_RUN, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
      end else begin
        send_item(ACT_UNUSED, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
      end
    end
    in_valid_i <= 1'b0;

    // Drain: let the checker see the final item, wait for every expected item, then
    // give a stray one time to show up.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (2 * SIZE + 8) @(posedge clk_i);

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
